/* src/assert_macros.svh */
// Assertion macros shared by the frame receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_AT(label, clk, rst_n, !(cond))

`endif

/* src/crcfr_pkg.sv */
// Types, constants and the CRC-16/ARC byte step for the frame receiver.
`timescale 1ns / 1ps

package crcfr_pkg;

    localparam int MAX_AREA_DEFAULT = 1024;

    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
    localparam logic [31:0] LEN_SAT_LIMIT = 32'd2047;
    localparam logic [10:0] LEN_SAT_VALUE = 11'h7FF;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 8'd1;

    typedef enum logic [3:0] {
        PH_HUNT1 = 4'd0,
        PH_HUNT2 = 4'd1,
        PH_CMD   = 4'd2,
        PH_PAD   = 4'd3,
        PH_LEN0  = 4'd4,
        PH_LEN1  = 4'd5,
        PH_LEN2  = 4'd6,
        PH_LEN3  = 4'd7,
        PH_HCRC0 = 4'd8,
        PH_HCRC1 = 4'd9,
        PH_DATA  = 4'd10,
        PH_DCRC0 = 4'd11,
        PH_DCRC1 = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_HDR_BAD  = 2'd1,
        ST_DATA_BAD = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_offset;
        logic        frame_done;
        status_t     frame_status;
        logic [7:0]  frame_command;
        logic [10:0] frame_length;
    } result_t;

    // One reflected CRC-16/ARC byte step, LSB first.
    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    localparam logic [15:0] SYNC_CRC_RESET = crc16_arc_byte(16'h0000, SYNC_FIRST_RESET);

endpackage

/* src/crcfr_parser.sv */
// Frame parser: phase machine, CRC check and per-byte result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crcfr_parser #(
    parameter int MAX_AREA = crcfr_pkg::MAX_AREA_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          sync_first,
    input  logic [7:0]          sync_second,
    input  logic [15:0]         sync_crc,
    output crcfr_pkg::result_t  result
);
    import crcfr_pkg::*;

    localparam int AW = $clog2(MAX_AREA + 1);
    localparam int WW = (AW > 10) ? AW : 10;

    phase_t        phase_reg, phase_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [7:0]    pad_reg, pad_next;
    logic [31:0]   len_reg, len_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] end_reg, end_next;

    logic [15:0]   crc_upd;
    logic [32:0]   area_sum;
    logic          too_long;
    logic          area_empty;
    logic [AW-1:0] cnt_inc;
    logic          area_last;
    logic [WW-1:0] off_w;
    logic          in_payload;
    logic [10:0]   len_sat;
    phase_t        resync;

    // Shared datapath terms
    assign crc_upd    = crc16_arc_byte(crc_reg, rx_byte);
    assign area_sum   = {1'b0, len_reg} + 33'(pad_reg);
    assign too_long   = (len_reg > 32'(MAX_AREA)) || (area_sum > 33'(MAX_AREA));
    assign area_empty = (area_sum == 33'd0);
    assign cnt_inc    = cnt_reg + AW'(1);
    assign area_last  = (cnt_inc >= end_reg);
    assign in_payload = (WW'(cnt_reg) >= WW'(pad_reg));
    assign off_w      = WW'(cnt_reg) - WW'(pad_reg);
    assign len_sat    = (len_reg > LEN_SAT_LIMIT) ? LEN_SAT_VALUE : len_reg[10:0];
    assign resync     = (rx_byte == sync_first) ? PH_HUNT2 : PH_HUNT1;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT1:
            begin
                if (rx_byte == sync_first)
                    phase_next = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                if (rx_byte == sync_second)
                    phase_next = PH_CMD;
                else if (rx_byte != sync_first)
                    phase_next = PH_HUNT1;
            end
            PH_CMD:   phase_next = PH_PAD;
            PH_PAD:   phase_next = PH_LEN0;
            PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3:
                phase_next = phase_t'(phase_reg + 4'd1);
            PH_HCRC0: phase_next = PH_HCRC1;
            PH_HCRC1:
            begin
                if (crc_upd != 16'h0000 || too_long)
                    phase_next = resync;
                else if (area_empty)
                    phase_next = PH_DCRC0;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (area_last)
                    phase_next = PH_DCRC0;
            end
            PH_DCRC0: phase_next = PH_DCRC1;
            PH_DCRC1:
            begin
                if (crc_upd == 16'h0000)
                    phase_next = PH_HUNT1;
                else
                    phase_next = resync;
            end
            default:  phase_next = resync;
        endcase
    end

    // Frame fields and the result for this byte
    always_comb
    begin
        crc_next = crc_reg;
        cmd_next = cmd_reg;
        pad_next = pad_reg;
        len_next = len_reg;
        cnt_next = cnt_reg;
        end_next = end_reg;
        result.payload_valid  = 1'b0;
        result.payload_byte   = 8'h00;
        result.payload_offset = 10'd0;
        result.frame_done     = 1'b0;
        result.frame_status   = ST_GOOD;
        result.frame_command  = 8'h00;
        result.frame_length   = 11'd0;
        unique case (phase_reg)
            PH_HUNT1: ;
            PH_HUNT2:
            begin
                if (rx_byte == sync_second)
                    crc_next = crc16_arc_byte(sync_crc, sync_second);
            end
            PH_CMD:
            begin
                crc_next = crc_upd;
                cmd_next = rx_byte;
            end
            PH_PAD:
            begin
                crc_next = crc_upd;
                pad_next = rx_byte;
                len_next = 32'h0;
            end
            PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3:
            begin
                crc_next = crc_upd;
                len_next[{phase_reg[1:0], 3'b000} +: 8] = rx_byte;
            end
            PH_HCRC0: crc_next = crc_upd;
            PH_HCRC1:
            begin
                crc_next = crc_upd;
                if (crc_upd != 16'h0000)
                begin
                    result.frame_done    = 1'b1;
                    result.frame_status  = ST_HDR_BAD;
                    result.frame_command = cmd_reg;
                    result.frame_length  = len_sat;
                end
                else if (too_long)
                begin
                    result.frame_done    = 1'b1;
                    result.frame_status  = ST_TOO_LONG;
                    result.frame_command = cmd_reg;
                    result.frame_length  = len_sat;
                end
                else
                begin
                    crc_next = 16'h0000;
                    cnt_next = '0;
                    end_next = area_sum[AW-1:0];
                end
            end
            PH_DATA:
            begin
                crc_next = crc_upd;
                cnt_next = cnt_inc;
                if (in_payload)
                begin
                    result.payload_valid  = 1'b1;
                    result.payload_byte   = rx_byte;
                    result.payload_offset = off_w[9:0];
                end
            end
            PH_DCRC0: crc_next = crc_upd;
            PH_DCRC1:
            begin
                crc_next = crc_upd;
                result.frame_done    = 1'b1;
                result.frame_status  = (crc_upd == 16'h0000) ? ST_GOOD : ST_DATA_BAD;
                result.frame_command = cmd_reg;
                result.frame_length  = len_sat;
            end
            default: ;
        endcase
    end

    // Advance the frame state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            crc_reg   <= 16'h0000;
            cmd_reg   <= 8'h00;
            pad_reg   <= 8'h00;
            len_reg   <= 32'h0;
            cnt_reg   <= '0;
            end_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            cmd_reg   <= cmd_next;
            pad_reg   <= pad_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            end_reg   <= end_next;
        end
    end

    // Area counter stays inside the accepted area; the data CRC phase returns to hunting
    `ASSERT_AT(a_cnt_in_area, clk, rst_n, (phase_reg == PH_DATA) |-> (cnt_reg < end_reg))
    `ASSERT_AT(a_end_bound, clk, rst_n, (phase_reg == PH_DATA) |-> (end_reg <= AW'(MAX_AREA)))
    `ASSERT_AT(a_dcrc_reports, clk, rst_n,
               (step && phase_reg == PH_DCRC1) |=> (phase_reg == PH_HUNT1 || phase_reg == PH_HUNT2))

endmodule

/* src/crc16_framed_serial_receiver_core.sv */
// Top level of the CRC-16/ARC checked serial frame receiver.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  input   | in        | in_valid / in_ready   | rx_byte
//  output  | out       | out_valid / out_ready | payload_*, frame_* (one per byte)
//  config  | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One byte per cycle sustained while the skid entry is empty; each byte passes the input
//  register, then the parser stage with its CRC byte step, into the result register
//  of the output buffer.
//  Reset clears the frame state to hunting the first sync byte and loads the sync
//  values 0xAA and 0x55; configuration writes are always ready.
//  A two-entry output buffer holds results while the output stalls; in_ready drops
//  only when the skid entry is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc16_framed_serial_receiver_core #(
    parameter int MAX_AREA = crcfr_pkg::MAX_AREA_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            rx_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  payload_valid,
    output logic [7:0]                            payload_byte,
    output logic [9:0]                            payload_offset,
    output logic                                  frame_done,
    output logic [1:0]                            frame_status,
    output logic [7:0]                            frame_command,
    output logic [10:0]                           frame_length,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [crcfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [7:0]                            cfg_data
);
    import crcfr_pkg::*;

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [15:0] sync_crc_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;

    result_t     result;
    result_t     head_reg;
    result_t     skid_reg;
    logic        head_valid_reg;
    logic        skid_valid_reg;

    logic        fire;
    logic        in_take;

    assign cfg_ready = 1'b1;
    assign fire      = s1_valid_reg && !skid_valid_reg;
    assign in_ready  = !s1_valid_reg || fire;
    assign in_take   = in_valid && in_ready;

    // Register writes; keep the CRC of the first sync byte alongside it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
            sync_crc_reg    <= SYNC_CRC_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:
                begin
                    sync_first_reg <= cfg_data;
                    sync_crc_reg   <= crc16_arc_byte(16'h0000, cfg_data);
                end
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the accepted byte for the parser stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_byte_reg <= rx_byte;
    end

    crcfr_parser #(
        .MAX_AREA (MAX_AREA)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (fire),
        .rx_byte     (s1_byte_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .sync_crc    (sync_crc_reg),
        .result      (result)
    );

    // Output buffer: head entry drives the port, skid catches a stalled transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (head_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                head_valid_reg <= 1'b1;
        end
        else if (head_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                head_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (head_valid_reg && !out_ready)
                skid_reg <= result;
            else
                head_reg <= result;
        end
        else if (head_valid_reg && out_ready && skid_valid_reg)
        begin
            head_reg <= skid_reg;
        end
    end

    // Drive the result ports from the head entry
    assign out_valid      = head_valid_reg;
    assign payload_valid  = head_reg.payload_valid;
    assign payload_byte   = head_reg.payload_byte;
    assign payload_offset = head_reg.payload_offset;
    assign frame_done     = head_reg.frame_done;
    assign frame_status   = head_reg.frame_status;
    assign frame_command  = head_reg.frame_command;
    assign frame_length   = head_reg.frame_length;

    `ASSERT_AT(a_skid_behind_head, clk, rst_n, skid_valid_reg |-> head_valid_reg)
    `ASSERT_NEVER(a_payload_not_end, clk, rst_n, out_valid && payload_valid && frame_done)
    `ASSERT_AT(a_good_len_bound, clk, rst_n,
               (out_valid && frame_done && frame_status == ST_GOOD)
               |-> (32'(frame_length) <= 32'(MAX_AREA)))

endmodule

/* sim/crc16_framed_serial_receiver_core_tb.sv */
// Self-checking testbench for the CRC-16/ARC framed serial receiver core.
`timescale 1ns / 1ps

module crc16_framed_serial_receiver_core_tb;
    import crcfr_pkg::*;

    localparam int AREA_LIMIT  = MAX_AREA_DEFAULT;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;
    localparam int DIR_ROWS    = 17;

    typedef enum logic { ROW_BYTE, ROW_FRAME } row_kind_t;
    typedef enum logic [1:0] { FLT_NONE, FLT_HDR, FLT_DATA, FLT_CUT } fault_t;

    // One directed row: a lone byte, or a frame with its typed frame-end report
    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  val;
        logic [7:0]  pad;
        logic [31:0] len;
        fault_t      fault;
        logic        tail;
        status_t     st;
        logic [10:0] flen;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_offset;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [7:0]  frame_command;
    logic [10:0] frame_length;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]  cfg_data;

    crc16_framed_serial_receiver_core #(
        .MAX_AREA(AREA_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .payload_valid(payload_valid),
        .payload_byte(payload_byte),
        .payload_offset(payload_offset),
        .frame_done(frame_done),
        .frame_status(frame_status),
        .frame_command(frame_command),
        .frame_length(frame_length),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Directed lone bytes and frames, each frame checked at frame end against the typed report
    stim_row_t dir_tab [DIR_ROWS] = '{
        '{ROW_BYTE,  8'h00, 8'd0,   32'd0,        FLT_NONE, 1'b0, ST_GOOD,     11'd0},
        '{ROW_BYTE,  8'hFF, 8'd0,   32'd0,        FLT_NONE, 1'b0, ST_GOOD,     11'd0},
        '{ROW_BYTE,  8'h55, 8'd0,   32'd0,        FLT_NONE, 1'b0, ST_GOOD,     11'd0},
        '{ROW_FRAME, 8'h00, 8'd0,   32'd0,        FLT_NONE, 1'b0, ST_GOOD,     11'd0},
        '{ROW_FRAME, 8'hFF, 8'd2,   32'd3,        FLT_DATA, 1'b0, ST_DATA_BAD, 11'd3},
        '{ROW_FRAME, 8'h5A, 8'd0,   32'd1,        FLT_HDR,  1'b0, ST_HDR_BAD,  11'd1},
        '{ROW_FRAME, 8'h01, 8'd1,   32'd1024,     FLT_NONE, 1'b0, ST_TOO_LONG, 11'd1024},
        '{ROW_FRAME, 8'h80, 8'd0,   32'd1025,     FLT_NONE, 1'b0, ST_TOO_LONG, 11'd1025},
        '{ROW_FRAME, 8'h7E, 8'd0,   32'd2047,     FLT_NONE, 1'b0, ST_TOO_LONG, 11'd2047},
        '{ROW_FRAME, 8'h7F, 8'd0,   32'd2048,     FLT_NONE, 1'b0, ST_TOO_LONG, 11'd2047},
        '{ROW_FRAME, 8'hC3, 8'hFF,  32'hFFFF_FFFF, FLT_NONE, 1'b0, ST_TOO_LONG, 11'd2047},
        '{ROW_FRAME, 8'h3C, 8'd0,   32'd1,        FLT_NONE, 1'b0, ST_GOOD,     11'd1},
        '{ROW_FRAME, 8'h11, 8'd3,   32'd2,        FLT_HDR,  1'b1, ST_HDR_BAD,  11'd2},
        '{ROW_FRAME, 8'h22, 8'd1,   32'd2,        FLT_NONE, 1'b0, ST_GOOD,     11'd2},
        '{ROW_FRAME, 8'h33, 8'd0,   32'd4,        FLT_DATA, 1'b1, ST_DATA_BAD, 11'd4},
        '{ROW_FRAME, 8'h44, 8'd0,   32'd0,        FLT_NONE, 1'b0, ST_GOOD,     11'd0},
        '{ROW_FRAME, 8'hA5, 8'd4,   32'd0,        FLT_NONE, 1'b0, ST_GOOD,     11'd0}
    };

    // Shadow of the sync registers and of the parser state
    logic [7:0]  sync_a = SYNC_FIRST_RESET;
    logic [7:0]  sync_b = SYNC_SECOND_RESET;
    phase_t      pr_phase = PH_HUNT1;
    logic [15:0] pr_crc = 16'h0000;
    logic [7:0]  pr_cmd = 8'h00;
    logic [7:0]  pr_pad = 8'h00;
    logic [31:0] pr_len = 32'h0;
    int unsigned pr_area = 0;

    result_t     awaited [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;
    int          quiet_cycles = 0;

    int          stall_mode = 0;
    int          stall_left = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    logic [3:0]  stall_tick = 4'd0;

    result_t     mon_got;
    result_t     mon_want;

    // Reflected CRC-16/ARC, fed one bit at a time, LSB first
    function automatic logic [15:0] arc_update(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ d[i])
                r = {1'b0, r[15:1]} ^ CRC_POLY;
            else
                r = {1'b0, r[15:1]};
        end
        return r;
    endfunction

    function automatic phase_t hunt_after_fail(input logic [7:0] b);
        return (b == sync_a) ? PH_HUNT2 : PH_HUNT1;
    endfunction

    function automatic result_t frame_end(input status_t st);
        result_t r;
        r = '0;
        r.frame_done    = 1'b1;
        r.frame_status  = st;
        r.frame_command = pr_cmd;
        r.frame_length  = (pr_len > LEN_SAT_LIMIT) ? LEN_SAT_VALUE : pr_len[10:0];
        return r;
    endfunction

    // Advance the parser shadow by one byte and form its report
    task automatic parse_byte(input logic [7:0] b, output result_t r);
        int idx;
        r = '0;
        case (pr_phase)
            PH_HUNT1:
            begin
                if (b == sync_a)
                    pr_phase = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                if (b == sync_b)
                begin
                    pr_crc = arc_update(arc_update(16'h0000, sync_a), sync_b);
                    pr_phase = PH_CMD;
                end
                else if (b != sync_a)
                    pr_phase = PH_HUNT1;
            end
            PH_CMD:
            begin
                pr_crc = arc_update(pr_crc, b);
                pr_cmd = b;
                pr_phase = PH_PAD;
            end
            PH_PAD:
            begin
                pr_crc = arc_update(pr_crc, b);
                pr_pad = b;
                pr_len = 32'h0;
                pr_phase = PH_LEN0;
            end
            PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3:
            begin
                pr_crc = arc_update(pr_crc, b);
                idx = int'(pr_phase) - int'(PH_LEN0);
                pr_len[8*idx +: 8] = b;
                pr_phase = phase_t'(int'(pr_phase) + 1);
            end
            PH_HCRC0:
            begin
                pr_crc = arc_update(pr_crc, b);
                pr_phase = PH_HCRC1;
            end
            PH_HCRC1:
            begin
                pr_crc = arc_update(pr_crc, b);
                if (pr_crc != 16'h0000)
                begin
                    r = frame_end(ST_HDR_BAD);
                    pr_phase = hunt_after_fail(b);
                end
                else if (pr_len > AREA_LIMIT || ({24'd0, pr_pad} + pr_len) > AREA_LIMIT)
                begin
                    r = frame_end(ST_TOO_LONG);
                    pr_phase = hunt_after_fail(b);
                end
                else
                begin
                    pr_crc = 16'h0000;
                    pr_area = 0;
                    pr_phase = (({24'd0, pr_pad} + pr_len) == 0) ? PH_DCRC0 : PH_DATA;
                end
            end
            PH_DATA:
            begin
                pr_crc = arc_update(pr_crc, b);
                if (pr_area >= pr_pad)
                begin
                    r.payload_valid  = 1'b1;
                    r.payload_byte   = b;
                    r.payload_offset = 10'(pr_area - pr_pad);
                end
                pr_area++;
                if (pr_area >= ({24'd0, pr_pad} + pr_len))
                    pr_phase = PH_DCRC0;
            end
            PH_DCRC0:
            begin
                pr_crc = arc_update(pr_crc, b);
                pr_phase = PH_DCRC1;
            end
            PH_DCRC1:
            begin
                pr_crc = arc_update(pr_crc, b);
                if (pr_crc == 16'h0000)
                begin
                    r = frame_end(ST_GOOD);
                    pr_phase = PH_HUNT1;
                end
                else
                begin
                    r = frame_end(ST_DATA_BAD);
                    pr_phase = hunt_after_fail(b);
                end
            end
            default:
                pr_phase = hunt_after_fail(b);
        endcase
    endtask

    // Send one byte in bursts with random gaps; record its report on acceptance
    task automatic send_byte(input logic [7:0] b, input logic fixed, input result_t fixed_res);
        int gap;
        result_t got;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        bytes_sent++;
        parse_byte(b, got);
        awaited.push_back(fixed ? fixed_res : got);
    endtask

    // Build a frame with the current sync values and send it
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] pad,
                              input logic [31:0] len, input fault_t fault,
                              input logic tail, input logic skip_first,
                              input logic typed, input result_t typed_end);
        logic [7:0]  fr [$];
        logic [15:0] acc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        longint      area;
        int          cut;
        logic [7:0]  d;
        area = longint'(pad) + longint'(len);
        fr.push_back(sync_a);
        fr.push_back(sync_b);
        fr.push_back(cmd);
        fr.push_back(pad);
        fr.push_back(len[7:0]);
        fr.push_back(len[15:8]);
        fr.push_back(len[23:16]);
        fr.push_back(len[31:24]);
        acc = 16'h0000;
        foreach (fr[i])
            acc = arc_update(acc, fr[i]);
        lo = acc[7:0];
        hi = acc[15:8];
        // Break the low CRC byte; optionally end on a first-sync value
        if (fault == FLT_HDR)
        begin
            lo = lo ^ 8'h01;
            if (tail)
                hi = sync_a;
        end
        fr.push_back(lo);
        fr.push_back(hi);
        if (fault != FLT_HDR && len <= AREA_LIMIT && area <= AREA_LIMIT)
        begin
            acc = 16'h0000;
            for (longint i = 0; i < area; i++)
            begin
                d = 8'($urandom_range(0, 255));
                fr.push_back(d);
                acc = arc_update(acc, d);
            end
            lo = acc[7:0];
            hi = acc[15:8];
            if (fault == FLT_DATA)
            begin
                lo = lo ^ 8'h01;
                if (tail)
                    hi = sync_a;
            end
            fr.push_back(lo);
            fr.push_back(hi);
        end
        if (skip_first)
            void'(fr.pop_front());
        // Drop the tail of the frame to break the sequence
        if (fault == FLT_CUT)
        begin
            cut = $urandom_range(1, fr.size() - 1);
            while (fr.size() > cut)
                void'(fr.pop_back());
        end
        for (int i = 0; i < fr.size(); i++)
            send_byte(fr[i], typed && (i == fr.size() - 1), typed_end);
    endtask

    // Hold the input idle until every report has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val,
                             input logic last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
        if (idx == CFG_SYNC_FIRST)
            sync_a = val;
        else if (idx == CFG_SYNC_SECOND)
            sync_b = val;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver stall pattern: always ready, coin flip, rotating mask, mostly stalled
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_mask = 16'($urandom_range(0, 65535));
            stall_left = $urandom_range(32, 256);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 0);
            2:       out_ready <= stall_mask[stall_tick];
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each output transaction with the oldest awaited report
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            mon_got.payload_valid  = payload_valid;
            mon_got.payload_byte   = payload_byte;
            mon_got.payload_offset = payload_offset;
            mon_got.frame_done     = frame_done;
            mon_got.frame_status   = status_t'(frame_status);
            mon_got.frame_command  = frame_command;
            mon_got.frame_length   = frame_length;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $write("%0t: unexpected result ", $time);
                    $display("pv=%0b pb=%02h po=%0d fd=%0b fs=%0d fc=%02h fl=%0d",
                             payload_valid, payload_byte, payload_offset, frame_done,
                             frame_status, frame_command, frame_length);
                end
            end
            else
            begin
                mon_want = awaited.pop_front();
                if (mon_got.payload_valid !== mon_want.payload_valid ||
                    mon_got.payload_byte !== mon_want.payload_byte ||
                    mon_got.payload_offset !== mon_want.payload_offset ||
                    mon_got.frame_done !== mon_want.frame_done ||
                    mon_got.frame_status !== mon_want.frame_status ||
                    mon_got.frame_command !== mon_want.frame_command ||
                    mon_got.frame_length !== mon_want.frame_length)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $write("%0t: mismatch want pv=%0b pb=%02h po=%0d fd=%0b fs=%0d ",
                               $time, mon_want.payload_valid, mon_want.payload_byte,
                               mon_want.payload_offset, mon_want.frame_done,
                               mon_want.frame_status);
                        $write("fc=%02h fl=%0d ", mon_want.frame_command,
                               mon_want.frame_length);
                        $display("got pv=%0b pb=%02h po=%0d fd=%0b fs=%0d fc=%02h fl=%0d",
                                 payload_valid, payload_byte, payload_offset, frame_done,
                                 frame_status, frame_command, frame_length);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t   row;
        result_t     want;
        logic        skip;
        logic        prev_tail;
        logic        tail;
        logic [7:0]  f;
        logic [7:0]  s;
        logic [7:0]  pad;
        logic [31:0] len;
        fault_t      fault;
        int          start;
        int          pick;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = 8'h00;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table under the reset sync values
        skip = 1'b0;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_tab[i];
            if (row.kind == ROW_BYTE)
                send_byte(row.val, 1'b1, '0);
            else
            begin
                want = '0;
                want.frame_done    = 1'b1;
                want.frame_status  = row.st;
                want.frame_command = row.val;
                want.frame_length  = row.flen;
                send_frame(row.val, row.pad, row.len, row.fault, row.tail, skip, 1'b1, want);
                skip = row.tail;
            end
        end

        // Random frames, one sync setting per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    f = 8'hAA;
                    s = 8'h55;
                end
                1:
                begin
                    f = 8'h00;
                    s = 8'hFF;
                end
                2:
                begin
                    f = 8'hFF;
                    s = 8'h00;
                end
                3:
                begin
                    f = 8'h5A;
                    s = 8'h5A;
                end
                default:
                begin
                    f = 8'($urandom_range(0, 255));
                    s = 8'($urandom_range(0, 255));
                end
            endcase
            // Writes beyond the two registers must leave them alone
            if (ph == 3)
            begin
                write_reg(8'd2, 8'($urandom_range(0, 255)), 1'b0);
                write_reg(8'hFF, 8'($urandom_range(0, 255)), 1'b0);
            end
            write_reg(CFG_SYNC_FIRST, f, 1'b0);
            write_reg(CFG_SYNC_SECOND, s, 1'b1);
            // One frame filling the whole area, offsets up to the top
            if (ph == 0)
                send_frame(8'($urandom_range(0, 255)), 8'd0, 32'd1024, FLT_NONE, 1'b0, 1'b0,
                           1'b0, '0);
            start = bytes_sent;
            prev_tail = 1'b0;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                if (!prev_tail && $urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    pad = 8'($urandom_range(0, 3));
                else if (pick < 95)
                    pad = 8'($urandom_range(4, 24));
                else
                    pad = 8'($urandom_range(200, 255));
                len = $urandom_range(0, 12);
                fault = FLT_NONE;
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    fault = FLT_HDR;
                else if (pick < 24)
                    fault = FLT_DATA;
                else if (pick < 32)
                begin
                    if ($urandom_range(0, 1) == 0)
                        len = AREA_LIMIT + 1 - pad + $urandom_range(0, 40);
                    else
                        len = $urandom;
                end
                else if (pick < 40)
                    fault = FLT_CUT;
                tail = ($urandom_range(0, 2) == 0) && (fault == FLT_HDR || fault == FLT_DATA);
                send_frame(8'($urandom_range(0, 255)), pad, len, fault, tail, prev_tail,
                           1'b0, '0);
                prev_tail = tail;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && awaited.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
